[hw/rtl/pdfl_pkg.sv]
// ----------------------------------------------------------------------------
// pdfl_pkg: shared types and constants for the pooled deque
// Request and result layouts, operation and status codes, pointer widths,
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pdfl_pkg;

  // Pool geometry
  localparam int POOL_DEPTH  = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int IDX_W       = $clog2(POOL_DEPTH + 1);

  // Field widths
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 7;
  localparam int CAP_W    = 7;

  typedef logic [IDX_W-1:0] idx_t;

  // One past the last node marks the end of a chain
  localparam idx_t NIL_IDX = idx_t'(POOL_DEPTH);

  localparam logic [CAP_W-1:0] CAP_RESET =
    (64 > POOL_DEPTH) ? CAP_W'(POOL_DEPTH) : CAP_W'(64);

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH_HEAD = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_TAIL = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_HEAD  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_TAIL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic [VALUE_WIDTH-1:0] value;
  } pdfl_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [VALUE_WIDTH-1:0] out_value;
    logic [CNT_W-1:0]       item_count;
    logic                   is_empty;
    logic                   is_full;
  } pdfl_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH_LINK,
    ST_POP_UNLINK,
    ST_POP_FREE
  } pdfl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PUSH_ALLOC,
    OP_PUSH_LINK,
    OP_POP_READ,
    OP_POP_UNLINK,
    OP_POP_FREE,
    OP_CLEAR,
    OP_REFUSE_FULL,
    OP_REFUSE_EMPTY,
    OP_IDLE_RESP,
    OP_REBUILD
  } pdfl_op_t;

  typedef struct packed {
    pdfl_op_t op;
    logic     at_head;
  } pdfl_cmd_t;

  typedef struct packed {
    logic full;
    logic head_empty;
    logic tail_empty;
  } pdfl_stat_t;

endpackage

[hw/rtl/pdfl_ram.sv]
// ----------------------------------------------------------------------------
// pdfl_ram: generic simple dual-port RAM
// One write port, one read port, registered read data (old data on a
// same-address read and write).
// ----------------------------------------------------------------------------
module pdfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/pdfl_ctrl.sv]
// ----------------------------------------------------------------------------
// pdfl_ctrl: request sequencer
// Decode each request and step the datapath through its pointer updates.
// ----------------------------------------------------------------------------
module pdfl_ctrl
  import pdfl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [FUNC_W-1:0] func,
  input  logic              cfg_valid,
  input  pdfl_stat_t        stat,
  output logic              busy,
  output logic              cfg_ready,
  output pdfl_cmd_t         cmd
);

  pdfl_state_t state_r, state_nxt;
  logic        side_r, side_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      side_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      side_r  <= side_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    side_nxt    = side_r;
    cmd.op      = OP_NONE;
    cmd.at_head = side_r;
    busy        = (state_r != ST_IDLE);
    cfg_ready   = (state_r == ST_IDLE) && !start;
    unique case (state_r)
      ST_IDLE: begin
        // even codes act on the head, odd codes on the tail
        cmd.at_head = ~func[0];
        if (start) begin
          side_nxt = ~func[0];
          unique case (func) inside
            FUNC_PUSH_HEAD, FUNC_PUSH_TAIL: begin
              if (stat.full) begin
                cmd.op = OP_REFUSE_FULL;
              end else begin
                cmd.op    = OP_PUSH_ALLOC;
                state_nxt = ST_PUSH_LINK;
              end
            end
            FUNC_POP_HEAD, FUNC_POP_TAIL: begin
              if (func[0] ? stat.tail_empty : stat.head_empty) begin
                cmd.op = OP_REFUSE_EMPTY;
              end else begin
                cmd.op    = OP_POP_READ;
                state_nxt = ST_POP_UNLINK;
              end
            end
            FUNC_CLEAR: cmd.op = OP_CLEAR;
            default:    cmd.op = OP_IDLE_RESP;
          endcase
        end else if (cfg_valid) begin
          cmd.op = OP_REBUILD;
        end
      end
      ST_PUSH_LINK: begin
        cmd.op    = OP_PUSH_LINK;
        state_nxt = ST_IDLE;
      end
      ST_POP_UNLINK: begin
        cmd.op    = OP_POP_UNLINK;
        state_nxt = ST_POP_FREE;
      end
      ST_POP_FREE: begin
        cmd.op    = OP_POP_FREE;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/pdfl_dp.sv]
// ----------------------------------------------------------------------------
// pdfl_dp: pool datapath
// Node memories, list and free pointers, counters and the result register.
// ----------------------------------------------------------------------------
module pdfl_dp
  import pdfl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  pdfl_cmd_t        cmd,
  input  pdfl_in_t         in_data,
  input  logic [CAP_W-1:0] cfg_data,
  output pdfl_stat_t       stat,
  output logic             out_valid,
  output pdfl_out_t        out_data
);

  idx_t             head_r, head_nxt;
  idx_t             tail_r, tail_nxt;
  idx_t             free_r, free_nxt;
  idx_t             node_r, node_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] fresh_r, fresh_nxt;
  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             chain_r, chain_nxt;
  logic [VALUE_WIDTH-1:0] pop_val_r, pop_val_nxt;
  logic             out_valid_r, resp;
  pdfl_out_t        res_r, res_nxt;

  logic             nx_we, pv_we, val_we;
  logic [ADDR_W-1:0] nx_waddr, pv_waddr, nx_raddr, sel_addr;
  idx_t             nx_wdata, pv_wdata, nx_rd, pv_rd;
  logic [VALUE_WIDTH-1:0] val_rd;

  idx_t             sel_ptr, nb, alloc_idx;
  logic             from_fresh;
  logic [CAP_W-1:0] cap_sat;
  logic [STATUS_W-1:0] status;
  logic [VALUE_WIDTH-1:0] rval;

  pdfl_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_next_ram (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rd)
  );

  pdfl_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_prev_ram (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(sel_addr), .rdata(pv_rd)
  );

  pdfl_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(POOL_DEPTH)) u_value_ram (
    .clk(clk), .we(val_we), .waddr(alloc_idx[ADDR_W-1:0]), .wdata(in_data.value),
    .raddr(sel_addr), .rdata(val_rd)
  );

  assign sel_ptr    = cmd.at_head ? head_r : tail_r;
  assign sel_addr   = sel_ptr[ADDR_W-1:0];
  assign nb         = cmd.at_head ? nx_rd : pv_rd;
  // hand out never-used nodes first, then recycled ones
  assign from_fresh = (fresh_r != '0);
  assign alloc_idx  = from_fresh ? idx_t'(fresh_r - 1'b1) : free_r;
  assign nx_raddr   = (cmd.op == OP_POP_READ) ? sel_addr : free_r[ADDR_W-1:0];
  assign cap_sat    = (cfg_data > CAP_W'(POOL_DEPTH)) ? CAP_W'(POOL_DEPTH) : cfg_data;

  assign stat.full       = (count_r >= cap_r);
  assign stat.head_empty = (count_r == '0) || (head_r >= NIL_IDX);
  assign stat.tail_empty = (count_r == '0) || (tail_r >= NIL_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NIL_IDX;
      tail_r      <= NIL_IDX;
      free_r      <= NIL_IDX;
      count_r     <= '0;
      fresh_r     <= CNT_W'(CAP_RESET);
      cap_r       <= CAP_RESET;
      chain_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      cap_r       <= cap_nxt;
      chain_r     <= chain_nxt;
      out_valid_r <= resp;
    end
  end

  always_ff @(posedge clk) begin
    node_r    <= node_nxt;
    pop_val_r <= pop_val_nxt;
    if (resp) begin
      res_r <= res_nxt;
    end
  end

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    free_nxt    = free_r;
    node_nxt    = node_r;
    count_nxt   = count_r;
    fresh_nxt   = fresh_r;
    cap_nxt     = cap_r;
    chain_nxt   = chain_r;
    pop_val_nxt = pop_val_r;
    nx_we       = 1'b0;
    nx_waddr    = alloc_idx[ADDR_W-1:0];
    nx_wdata    = NIL_IDX;
    pv_we       = 1'b0;
    pv_waddr    = alloc_idx[ADDR_W-1:0];
    pv_wdata    = NIL_IDX;
    val_we      = 1'b0;
    resp        = 1'b0;
    status      = STAT_OK;
    rval        = '0;
    unique case (cmd.op)
      OP_PUSH_ALLOC: begin
        node_nxt  = alloc_idx;
        chain_nxt = !from_fresh;
        if (from_fresh) begin
          fresh_nxt = fresh_r - 1'b1;
        end
        val_we   = 1'b1;
        nx_we    = 1'b1;
        nx_wdata = cmd.at_head ? head_r : NIL_IDX;
        pv_we    = 1'b1;
        pv_wdata = cmd.at_head ? NIL_IDX : tail_r;
      end
      OP_PUSH_LINK: begin
        if (chain_r) begin
          free_nxt = nx_rd;
        end
        if (cmd.at_head) begin
          if (head_r < NIL_IDX) begin
            pv_we    = 1'b1;
            pv_waddr = head_r[ADDR_W-1:0];
            pv_wdata = node_r;
          end
          head_nxt = node_r;
          if (tail_r >= NIL_IDX) begin
            tail_nxt = node_r;
          end
        end else begin
          if (tail_r < NIL_IDX) begin
            nx_we    = 1'b1;
            nx_waddr = tail_r[ADDR_W-1:0];
            nx_wdata = node_r;
          end
          tail_nxt = node_r;
          if (head_r >= NIL_IDX) begin
            head_nxt = node_r;
          end
        end
        count_nxt = count_r + 1'b1;
        resp      = 1'b1;
      end
      OP_POP_READ: node_nxt = sel_ptr;
      OP_POP_UNLINK: begin
        pop_val_nxt = val_rd;
        if (cmd.at_head) begin
          head_nxt = nb;
          if (nb < NIL_IDX) begin
            pv_we    = 1'b1;
            pv_waddr = nb[ADDR_W-1:0];
          end else begin
            tail_nxt = NIL_IDX;
          end
        end else begin
          tail_nxt = nb;
          if (nb < NIL_IDX) begin
            nx_we    = 1'b1;
            nx_waddr = nb[ADDR_W-1:0];
          end else begin
            head_nxt = NIL_IDX;
          end
        end
      end
      OP_POP_FREE: begin
        nx_we     = 1'b1;
        nx_waddr  = node_r[ADDR_W-1:0];
        nx_wdata  = free_r;
        free_nxt  = node_r;
        count_nxt = count_r - 1'b1;
        rval      = pop_val_r;
        resp      = 1'b1;
      end
      OP_CLEAR: begin
        // every node goes back to the pool at once
        head_nxt  = NIL_IDX;
        tail_nxt  = NIL_IDX;
        free_nxt  = NIL_IDX;
        count_nxt = '0;
        fresh_nxt = CNT_W'(cap_r);
        resp      = 1'b1;
      end
      OP_REBUILD: begin
        head_nxt  = NIL_IDX;
        tail_nxt  = NIL_IDX;
        free_nxt  = NIL_IDX;
        count_nxt = '0;
        cap_nxt   = cap_sat;
        fresh_nxt = CNT_W'(cap_sat);
      end
      OP_REFUSE_FULL: begin
        status = STAT_FULL;
        resp   = 1'b1;
      end
      OP_REFUSE_EMPTY: begin
        status = STAT_EMPTY;
        resp   = 1'b1;
      end
      OP_IDLE_RESP: resp = 1'b1;
      default: ;
    endcase
    res_nxt.status     = status;
    res_nxt.out_value  = rval;
    res_nxt.item_count = count_nxt;
    res_nxt.is_empty   = (count_nxt == '0);
    res_nxt.is_full    = (count_nxt == CNT_W'(cap_nxt));
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

endmodule

[hw/rtl/pooled_deque_free_list.sv]
// ----------------------------------------------------------------------------
// pooled_deque_free_list: double-ended list over a fixed node pool
// Top level: request sequencer plus pool datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive in_data (func, value) and raise start; the request
//   is taken at a rising edge with start high and busy low. func selects
//   push head, push tail, pop head, pop tail or clear; other codes do nothing
//   but still answer.
//   Result channel: every request yields exactly one result, shown on
//   out_data for one cycle while out_valid is high. The receiver cannot
//   stall; sample it on that cycle.
//   Flow: refused pushes, empty pops, clear and unknown codes answer the
//   cycle after the request; a push passes the link state and a pop the
//   unlink and free states. busy is high in those states and low in the
//   result cycle, so a new request can be taken while a result shows. The
//   steps are set by the next, prev and value RAMs: one write per RAM per
//   cycle and a registered read before a pop can relink its neighbor.
//   Configuration: cfg_data carries the capacity (saturated to the pool
//   depth) and is taken on cfg_valid and cfg_ready; it empties the list.
//   cfg_ready is high only while idle and no request is offered.
//   Reset: synchronous, active low; the list comes up empty with capacity
//   64 and no clearing pass, since never-used nodes are handed out by count.
// ----------------------------------------------------------------------------
module pooled_deque_free_list
  import pdfl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  pdfl_in_t         in_data,
  output logic             out_valid,
  output pdfl_out_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  pdfl_cmd_t  cmd;
  pdfl_stat_t stat;

  // Sequence each request into datapath steps
  pdfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .func      (in_data.func),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // Hold pointers, node memories and the result register
  pdfl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/pdfl_checker.sv]
// ----------------------------------------------------------------------------
// pdfl_checker: port-level checks for the pooled deque
// Watch the request, result and configuration ports over time.
// ----------------------------------------------------------------------------
module pdfl_checker
  import pdfl_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input pdfl_in_t         in_data,
  input logic             out_valid,
  input pdfl_out_t        out_data,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [CAP_W-1:0] cfg_data
);

  // A result follows a taken request or work in progress
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start) || $past(busy)))
    else $error("result without a request");

  // A capacity write produces no result
  a_cfg_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> !out_valid)
    else $error("result after capacity write");

  // Multi-cycle work never answers in its first busy cycle
  a_busy_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !out_valid)
    else $error("result at start of busy period");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STAT_EMPTY) |->
      (out_data.is_empty && out_data.item_count == '0 && out_data.out_value == '0))
    else $error("empty status with entries or data");

  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STAT_FULL) |->
      (out_data.is_full && out_data.out_value == '0))
    else $error("full status while not full");

endmodule

bind pooled_deque_free_list pdfl_checker u_pdfl_checker (.*);

[tb/pooled_deque_free_list_checker.sv]
// ----------------------------------------------------------------------------
// pooled_deque_free_list_checker: result checker for the pooled deque
// Watches the request, result and capacity channels, keeps a behavioral
// deque with the current capacity, and compares every result field by field
// against the oldest predicted result.
// ----------------------------------------------------------------------------
module pooled_deque_free_list_checker
  import pdfl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  pdfl_in_t         in_data,
  input  logic             out_valid,
  input  pdfl_out_t        out_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data,
  output int unsigned      mismatches,
  output int unsigned      outstanding
);

  logic [VALUE_WIDTH-1:0] list_vals[$];
  logic [CNT_W-1:0]       cap_limit;
  pdfl_out_t              due_results[$];
  int unsigned            err_cnt;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    err_cnt     = 0;
    cap_limit   = CAP_RESET;
  end

  // Run one request against the deque and return the result it should give
  function automatic pdfl_out_t apply_request(input pdfl_in_t req);
    pdfl_out_t res;
    res        = '0;
    res.status = STAT_OK;
    case (req.func)
      FUNC_PUSH_HEAD, FUNC_PUSH_TAIL: begin
        if (list_vals.size() < cap_limit) begin
          if (req.func == FUNC_PUSH_HEAD) list_vals.push_front(req.value);
          else list_vals.push_back(req.value);
        end else begin
          res.status = STAT_FULL;
        end
      end
      FUNC_POP_HEAD, FUNC_POP_TAIL: begin
        if (list_vals.size() == 0) begin
          res.status = STAT_EMPTY;
        end else if (req.func == FUNC_POP_HEAD) begin
          res.out_value = list_vals.pop_front();
        end else begin
          res.out_value = list_vals.pop_back();
        end
      end
      FUNC_CLEAR: list_vals.delete();
      default: ;
    endcase
    res.item_count = CNT_W'(list_vals.size());
    res.is_empty   = (list_vals.size() == 0);
    res.is_full    = (list_vals.size() == cap_limit);
    return res;
  endfunction

  task automatic check_field(input string name, input logic [VALUE_WIDTH-1:0] want,
                             input logic [VALUE_WIDTH-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    pdfl_out_t want;
    if (!rst_n) begin
      list_vals.delete();
      due_results.delete();
      cap_limit = CAP_RESET;
    end else begin
      // Results belong to earlier requests: compare before taking a new one
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $error("result with no request outstanding: 0x%0h", out_data);
          err_cnt++;
        end else begin
          want = due_results.pop_front();
          check_field("status",     VALUE_WIDTH'(want.status),     VALUE_WIDTH'(out_data.status));
          check_field("out_value",  want.out_value,                out_data.out_value);
          check_field("item_count", VALUE_WIDTH'(want.item_count), VALUE_WIDTH'(out_data.item_count));
          check_field("is_empty",   VALUE_WIDTH'(want.is_empty),   VALUE_WIDTH'(out_data.is_empty));
          check_field("is_full",    VALUE_WIDTH'(want.is_full),    VALUE_WIDTH'(out_data.is_full));
        end
      end
      if (cfg_valid && cfg_ready) begin
        cap_limit = (cfg_data > POOL_DEPTH) ? CNT_W'(POOL_DEPTH) : cfg_data;
        list_vals.delete();
      end
      if (start && !busy) due_results.push_back(apply_request(in_data));
    end
    mismatches  <= err_cnt;
    outstanding <= due_results.size();
  end

endmodule

[tb/pooled_deque_free_list_tb.sv]
// ----------------------------------------------------------------------------
// pooled_deque_free_list_tb: regression for the pooled deque
// Drives directed and random push, pop, clear and unknown requests under
// several capacities, with random gaps on the request side, and leaves the
// prediction and comparison to the checker instance.
// ----------------------------------------------------------------------------
module pooled_deque_free_list_tb;
  import pdfl_pkg::*;

  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 100;
  localparam int IDLE_PCT  = 21;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  pdfl_in_t         in_data;
  logic             out_valid;
  pdfl_out_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;
  int unsigned      mismatches;
  int unsigned      outstanding;
  bit               gaps_on;

  // Capacity and push bias per random phase: small pools fill and refuse
  // often, the push-heavy full pools reach the pool depth.
  int phase_cap[PHASES]      = '{64, 3, 0, 127, 1, -1, 64, 20};
  int phase_push_pct[PHASES] = '{55, 50, 60, 90, 50, 60, 92, 45};

  pooled_deque_free_list i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  pooled_deque_free_list_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs or stops answering
  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one request; hold start high until busy is low at an edge.
  // Gaps drop start and put junk on in_data, which must be ignored.
  task automatic issue(input logic [FUNC_W-1:0] func, input logic [VALUE_WIDTH-1:0] value);
    pdfl_in_t req;
    req.func  = func;
    req.value = value;
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      start   <= 1'b0;
      in_data <= pdfl_in_t'({$urandom(), $urandom()});
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every outstanding result has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write the capacity only once the block is quiet; this empties the list
  task automatic program_capacity(input logic [CAP_W-1:0] cap);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly random words, with the all-zero and all-one patterns mixed in
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func(input int push_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_pct) return $urandom_range(1) ? FUNC_PUSH_HEAD : FUNC_PUSH_TAIL;
    if (roll < 94)       return $urandom_range(1) ? FUNC_POP_HEAD : FUNC_POP_TAIL;
    if (roll < 97)       return FUNC_CLEAR;
    return FUNC_W'($urandom_range((1 << FUNC_W) - 1, FUNC_CLEAR + 1));
  endfunction

  initial begin
    int wait_cnt;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    gaps_on   = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset capacity, both ends, extreme values, empty pops,
    // unknown codes and clear on both empty and filled lists
    issue(FUNC_PUSH_HEAD, '0);
    issue(FUNC_PUSH_TAIL, '1);
    issue(FUNC_PUSH_HEAD, 32'h5A5A_A5A5);
    issue(FUNC_POP_TAIL, '0);
    issue(FUNC_POP_HEAD, '0);
    issue(FUNC_POP_HEAD, '0);
    issue(FUNC_POP_HEAD, '1);
    issue(FUNC_POP_TAIL, '1);
    issue(FUNC_W'(FUNC_CLEAR + 1), '1);
    issue(FUNC_W'((1 << FUNC_W) - 1), 32'h1234_5678);
    issue(FUNC_CLEAR, '0);
    issue(FUNC_PUSH_TAIL, 32'h0000_0001);
    issue(FUNC_PUSH_TAIL, 32'h8000_0000);
    issue(FUNC_CLEAR, '0);
    issue(FUNC_POP_TAIL, '0);

    // Zero capacity: empty and full at once, every push refused
    program_capacity(7'd0);
    issue(FUNC_PUSH_HEAD, 32'hDEAD_BEEF);
    issue(FUNC_POP_HEAD, '0);

    // Single node: second push refused
    program_capacity(7'd1);
    issue(FUNC_PUSH_TAIL, 32'h8000_0000);
    issue(FUNC_PUSH_HEAD, 32'h7FFF_FFFF);
    issue(FUNC_POP_TAIL, '0);

    // Capacity above the pool saturates to the pool depth
    program_capacity('1);
    issue(FUNC_PUSH_HEAD, 32'hCAFE_F00D);
    issue(FUNC_W'(FUNC_CLEAR + 2), '0);
    program_capacity(7'(POOL_DEPTH + 1));
    issue(FUNC_POP_HEAD, '0);

    // Random phases, each under its own capacity
    for (int ph = 0; ph < PHASES; ph++) begin
      program_capacity(phase_cap[ph] < 0 ? CAP_W'($urandom_range(127)) : CAP_W'(phase_cap[ph]));
      // Hold gaps off for one whole phase to run back to back
      gaps_on = (ph != 5);
      for (int i = 0; i < PHASE_LEN; i++) begin
        // Pause once mid-phase until all results are back
        if (ph == 2 && i == PHASE_LEN / 2) drain();
        issue(pick_func(phase_push_pct[ph]), pick_value());
      end
    end

    // Drain, bounded; anything still outstanding counts against the run
    start    <= 1'b0;
    wait_cnt = 0;
    do begin
      @(posedge clk);
      wait_cnt++;
    end while (outstanding != 0 && wait_cnt < 200);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/pdfl_pkg.sv
hw/rtl/pdfl_ram.sv
hw/rtl/pdfl_ctrl.sv
hw/rtl/pdfl_dp.sv
hw/rtl/pooled_deque_free_list.sv
hw/rtl/pdfl_checker.sv
tb/pooled_deque_free_list_checker.sv
tb/pooled_deque_free_list_tb.sv
